@@ src/stdp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stdp_pkg;

	localparam int unsigned COORD_W  = 24;
	localparam int unsigned RADIUS_W = 18;
	localparam int unsigned WEIGHT_W = 15;
	localparam int unsigned PEN_W    = 32;
	localparam int unsigned CNT_OUT_W = 7;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned SQ_W     = 50;	// squared distances, Q.16
	localparam int unsigned RR_W     = 36;	// squared radius
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned LENF_W   = 29;

	localparam logic [SQ_W-1:0]   LEN2_CAP = SQ_W'(64'd1 << 28);
	localparam logic [LENF_W-1:0] LENF_ONE = LENF_W'(64'd1 << 20);
	localparam logic [FRAC_W:0]   FRAC_ONE = 17'h10000;
	localparam logic [PEN_W-1:0]  PEN_MAX  = '1;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X = 1'b0,
		REG_START_Y = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [COORD_W-1:0]  threat_x;
		logic [COORD_W-1:0]  threat_y;
		logic [RADIUS_W-1:0] threat_radius;
		logic [WEIGHT_W-1:0] threat_weight;
		logic [COORD_W-1:0]  seg_ax;
		logic [COORD_W-1:0]  seg_ay;
		logic [COORD_W-1:0]  seg_bx;
		logic [COORD_W-1:0]  seg_by;
	} in_t;

	typedef struct packed {
		logic [PEN_W-1:0]     penalty;
		logic                 load_dropped;
		logic [CNT_OUT_W-1:0] threat_count;
	} out_t;

	typedef struct packed {
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [RADIUS_W-1:0] radius;
		logic [WEIGHT_W-1:0] weight;
		logic                start_inside;
	} disk_t;

	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] num;
		logic [SQ_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD_X,
		ST_LOAD_Y,
		ST_LOAD_R,
		ST_LEN_X,
		ST_LEN_Y,
		ST_FETCH,
		ST_RR,
		ST_DA_X,
		ST_DA_Y,
		ST_DB_X,
		ST_DB_Y,
		ST_T_X,
		ST_T_Y,
		ST_T_CHK,
		ST_UDIV,
		ST_P_X,
		ST_P_X2,
		ST_P_Y,
		ST_P_Y2,
		ST_D_X,
		ST_D_Y,
		ST_D_CHK,
		ST_FDIV,
		ST_W,
		ST_L,
		ST_ACC,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ src/stdp_frac16.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: floor(num * 2^16 / den), num < den, one quotient bit a cycle.
module stdp_frac16 (
	input  wire                     clk,
	input  wire                     arst_n,
	input  stdp_pkg::div_req_t      req,
	output stdp_pkg::div_rsp_t      rsp
);

	logic [stdp_pkg::SQ_W-1:0]   rem_q;
	logic [stdp_pkg::SQ_W-1:0]   den_q;
	logic [stdp_pkg::FRAC_W-1:0] quo_q;
	logic [3:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [stdp_pkg::SQ_W:0]     rem2;
	logic                        ge;

	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge   = rem2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? stdp_pkg::SQ_W'(rem2 - {1'b0, den_q}) : rem2[stdp_pkg::SQ_W-1:0];
			quo_q <= {quo_q[stdp_pkg::FRAC_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

`default_nettype wire

@@ src/segment_threat_disk_penalty_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Threat-disk penalty for route segments.
// Input channel in_valid / in_stall / in_data carries one transaction per item:
//   clear the disk table, load one disk, or query the penalty of a segment.
// Output channel out_valid / out_stall / out_data returns exactly one
//   transaction per item: penalty (Q24.8, saturating), drop flag, disk count.
// Config port cfg_we / cfg_index / cfg_wdata sets the route start used to flag
//   disks that contain it; write only while the block is idle.
// Items are handled one at a time by a sequencer around a disk memory with one
//   write port and one registered read port, one shared multiplier and a 16-step divider.
// A query visits every stored disk in turn; a point segment or an empty table
//   skips the disk loop, and a disk that is reached may need two divisions
//   (projection and closeness) on the shared divider.
// A finished result sits in the output register; the next item is taken while
//   it waits, but its own result holds in the sequencer until the register frees.
// Reset empties the table (count to zero) and clears the start registers; disk
//   contents are not cleared, entries beyond the count are never used.
module segment_threat_disk_penalty_top #(
	parameter int unsigned THREAT_SLOTS = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  stdp_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  wire                                out_stall,
	output stdp_pkg::out_t                     out_data,
	input  wire                                cfg_we,
	input  wire [stdp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [stdp_pkg::COORD_W-1:0]        cfg_wdata
);

	localparam int unsigned IW = (THREAT_SLOTS > 1) ? $clog2(THREAT_SLOTS) : 1;
	localparam int unsigned CW = $clog2(THREAT_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(THREAT_SLOTS);

	stdp_pkg::state_t state_q, state_d;

	stdp_pkg::in_t  in_q;
	stdp_pkg::out_t out_q;
	logic           out_valid_q;
	logic [stdp_pkg::COORD_W-1:0] start_x_q, start_y_q;
	logic [CW-1:0]  count_q;
	logic [IW-1:0]  idx_q;
	logic           dropped_q;

	// disk table
	stdp_pkg::disk_t mem [THREAT_SLOTS];
	stdp_pkg::disk_t rdata_q;
	stdp_pkg::disk_t wdisk;

	// datapath
	logic signed [62:0] acc_q;
	logic [stdp_pkg::SQ_W-1:0] len2_q, da_q, d_q;
	logic [stdp_pkg::LENF_W-1:0] lenf_q;
	logic [stdp_pkg::RR_W-1:0] rr_q;
	logic signed [51:0] t_q;
	logic [stdp_pkg::FRAC_W:0] u_q, f_q;
	logic signed [26:0] epx_q, epy_q;
	logic [stdp_pkg::PEN_W-1:0] sum_q;

	logic signed [32:0] ma;
	logic signed [29:0] mb;
	logic signed [62:0] prod;

	logic signed [24:0] dx, dy, cax, cay, cbx, cby;
	logic signed [27:0] px_off;
	logic [stdp_pkg::SQ_W-1:0] sq_sum;
	logic signed [51:0] t_sum;
	logic [stdp_pkg::PEN_W:0] sum_ext;
	logic in_fire, out_fire, out_load, last_disk;

	stdp_pkg::div_req_t div_req;
	stdp_pkg::div_rsp_t div_rsp;

	function automatic logic signed [32:0] sext_a(input logic signed [26:0] v);
		return {{6{v[26]}}, v};
	endfunction

	function automatic logic signed [29:0] sext_b(input logic signed [26:0] v);
		return {{3{v[26]}}, v};
	endfunction

	stdp_frac16 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;
	assign out_load = (state_q == stdp_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign last_disk = ({1'b0, idx_q} + (IW+1)'(1)) >= (IW+1)'(count_q);

	// operand differences, all fit 25 bits signed
	always_comb begin
		dx  = $signed({1'b0, in_q.seg_bx}) - $signed({1'b0, in_q.seg_ax});
		dy  = $signed({1'b0, in_q.seg_by}) - $signed({1'b0, in_q.seg_ay});
		cax = $signed({1'b0, rdata_q.x}) - $signed({1'b0, in_q.seg_ax});
		cay = $signed({1'b0, rdata_q.y}) - $signed({1'b0, in_q.seg_ay});
		cbx = $signed({1'b0, rdata_q.x}) - $signed({1'b0, in_q.seg_bx});
		cby = $signed({1'b0, rdata_q.y}) - $signed({1'b0, in_q.seg_by});
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			stdp_pkg::ST_LOAD_X: begin
				ma = sext_a(27'($signed({1'b0, start_x_q}) - $signed({1'b0, in_q.threat_x})));
				mb = sext_b(27'($signed({1'b0, start_x_q}) - $signed({1'b0, in_q.threat_x})));
			end
			stdp_pkg::ST_LOAD_Y: begin
				ma = sext_a(27'($signed({1'b0, start_y_q}) - $signed({1'b0, in_q.threat_y})));
				mb = sext_b(27'($signed({1'b0, start_y_q}) - $signed({1'b0, in_q.threat_y})));
			end
			stdp_pkg::ST_LOAD_R: begin
				ma = {15'b0, in_q.threat_radius};
				mb = {12'b0, in_q.threat_radius};
			end
			stdp_pkg::ST_LEN_X: begin
				ma = sext_a(27'(dx));
				mb = sext_b(27'(dx));
			end
			stdp_pkg::ST_LEN_Y: begin
				ma = sext_a(27'(dy));
				mb = sext_b(27'(dy));
			end
			stdp_pkg::ST_RR: begin
				ma = {15'b0, rdata_q.radius};
				mb = {12'b0, rdata_q.radius};
			end
			stdp_pkg::ST_DA_X: begin
				ma = sext_a(27'(cax));
				mb = sext_b(27'(cax));
			end
			stdp_pkg::ST_DA_Y: begin
				ma = sext_a(27'(cay));
				mb = sext_b(27'(cay));
			end
			stdp_pkg::ST_DB_X: begin
				ma = sext_a(27'(cbx));
				mb = sext_b(27'(cbx));
			end
			stdp_pkg::ST_DB_Y: begin
				ma = sext_a(27'(cby));
				mb = sext_b(27'(cby));
			end
			stdp_pkg::ST_T_X: begin
				ma = sext_a(27'(cax));
				mb = sext_b(27'(dx));
			end
			stdp_pkg::ST_T_Y: begin
				ma = sext_a(27'(cay));
				mb = sext_b(27'(dy));
			end
			stdp_pkg::ST_P_X: begin
				ma = {16'b0, u_q};
				mb = sext_b(27'(dx));
			end
			stdp_pkg::ST_P_Y: begin
				ma = {16'b0, u_q};
				mb = sext_b(27'(dy));
			end
			stdp_pkg::ST_D_X: begin
				ma = sext_a(epx_q);
				mb = sext_b(epx_q);
			end
			stdp_pkg::ST_D_Y: begin
				ma = sext_a(epy_q);
				mb = sext_b(epy_q);
			end
			stdp_pkg::ST_W: begin
				ma = {16'b0, f_q};
				mb = {15'b0, rdata_q.weight};
			end
			stdp_pkg::ST_L: begin
				ma = {1'b0, acc_q[31:0]};
				mb = {1'b0, lenf_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod   = ma * mb;
	assign sq_sum = acc_q[stdp_pkg::SQ_W-1:0] + prod[stdp_pkg::SQ_W-1:0];
	assign t_sum  = $signed(acc_q[51:0]) + $signed(prod[51:0]);
	// nearest point offset: round half up of u*delta, Q.24 to Q.8
	assign px_off = 28'(($signed(acc_q[41:0]) + 42'sd32768) >>> 16);
	assign sum_ext = {1'b0, sum_q} + (stdp_pkg::PEN_W+1)'(acc_q[60:36]);

	// divider request
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = t_q[stdp_pkg::SQ_W-1:0];
		div_req.den   = len2_q;
		case (state_q)
			stdp_pkg::ST_T_CHK: begin
				div_req.start = (t_q > 52'sd0) && (t_q < $signed({2'b0, len2_q}));
			end
			stdp_pkg::ST_D_CHK: begin
				div_req.start = (d_q < {14'b0, rr_q}) && (d_q != '0);
				div_req.num   = {14'b0, rr_q} - d_q;
				div_req.den   = {14'b0, rr_q};
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != stdp_pkg::ST_IDLE);
		case (state_q)
			stdp_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (stdp_pkg::kind_t'(in_data.kind))
						stdp_pkg::KIND_LOAD:
							state_d = (count_q >= SLOTS_C) ? stdp_pkg::ST_DONE
								: stdp_pkg::ST_LOAD_X;
						stdp_pkg::KIND_QUERY: state_d = stdp_pkg::ST_LEN_X;
						default: state_d = stdp_pkg::ST_DONE;
					endcase
				end
			end
			stdp_pkg::ST_LOAD_X: state_d = stdp_pkg::ST_LOAD_Y;
			stdp_pkg::ST_LOAD_Y: state_d = stdp_pkg::ST_LOAD_R;
			stdp_pkg::ST_LOAD_R: state_d = stdp_pkg::ST_DONE;
			stdp_pkg::ST_LEN_X: begin
				if ((dx == '0 && dy == '0) || count_q == '0) begin
					state_d = stdp_pkg::ST_DONE;
				end else begin
					state_d = stdp_pkg::ST_LEN_Y;
				end
			end
			stdp_pkg::ST_LEN_Y: state_d = stdp_pkg::ST_FETCH;
			stdp_pkg::ST_FETCH: state_d = stdp_pkg::ST_RR;
			stdp_pkg::ST_RR: begin
				state_d = rdata_q.start_inside ? stdp_pkg::ST_DA_X : stdp_pkg::ST_T_X;
			end
			stdp_pkg::ST_DA_X: state_d = stdp_pkg::ST_DA_Y;
			stdp_pkg::ST_DA_Y: state_d = stdp_pkg::ST_DB_X;
			stdp_pkg::ST_DB_X: state_d = stdp_pkg::ST_DB_Y;
			stdp_pkg::ST_DB_Y: begin
				// start disk left behind: skip unless B is nearer the centre than A
				state_d = (sq_sum >= da_q) ? stdp_pkg::ST_NEXT : stdp_pkg::ST_T_X;
			end
			stdp_pkg::ST_T_X: state_d = stdp_pkg::ST_T_Y;
			stdp_pkg::ST_T_Y: state_d = stdp_pkg::ST_T_CHK;
			stdp_pkg::ST_T_CHK: begin
				state_d = div_req.start ? stdp_pkg::ST_UDIV : stdp_pkg::ST_P_X;
			end
			stdp_pkg::ST_UDIV: begin
				if (div_rsp.done) begin
					state_d = stdp_pkg::ST_P_X;
				end
			end
			stdp_pkg::ST_P_X:  state_d = stdp_pkg::ST_P_X2;
			stdp_pkg::ST_P_X2: state_d = stdp_pkg::ST_P_Y;
			stdp_pkg::ST_P_Y:  state_d = stdp_pkg::ST_P_Y2;
			stdp_pkg::ST_P_Y2: state_d = stdp_pkg::ST_D_X;
			stdp_pkg::ST_D_X:  state_d = stdp_pkg::ST_D_Y;
			stdp_pkg::ST_D_Y:  state_d = stdp_pkg::ST_D_CHK;
			stdp_pkg::ST_D_CHK: begin
				if (d_q >= {14'b0, rr_q}) begin
					state_d = stdp_pkg::ST_NEXT;
				end else if (div_req.start) begin
					state_d = stdp_pkg::ST_FDIV;
				end else begin
					state_d = stdp_pkg::ST_W;
				end
			end
			stdp_pkg::ST_FDIV: begin
				if (div_rsp.done) begin
					state_d = stdp_pkg::ST_W;
				end
			end
			stdp_pkg::ST_W:   state_d = stdp_pkg::ST_L;
			stdp_pkg::ST_L:   state_d = stdp_pkg::ST_ACC;
			stdp_pkg::ST_ACC: state_d = stdp_pkg::ST_NEXT;
			stdp_pkg::ST_NEXT: begin
				state_d = last_disk ? stdp_pkg::ST_DONE : stdp_pkg::ST_FETCH;
			end
			stdp_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = stdp_pkg::ST_IDLE;
				end
			end
			default: state_d = stdp_pkg::ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stdp_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			start_x_q   <= '0;
			start_y_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (stdp_pkg::cfg_reg_t'(cfg_index))
					stdp_pkg::REG_START_X: start_x_q <= cfg_wdata;
					stdp_pkg::REG_START_Y: start_y_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (in_fire && stdp_pkg::kind_t'(in_data.kind) == stdp_pkg::KIND_CLEAR) begin
				count_q <= '0;
			end else if (state_q == stdp_pkg::ST_LOAD_R) begin
				count_q <= count_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// disk memory: one write port, one registered read port
	always_comb begin
		wdisk.x            = in_q.threat_x;
		wdisk.y            = in_q.threat_y;
		wdisk.radius       = in_q.threat_radius;
		wdisk.weight       = in_q.threat_weight;
		wdisk.start_inside = da_q < {14'b0, prod[stdp_pkg::RR_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (state_q == stdp_pkg::ST_LOAD_R) begin
			mem[count_q[IW-1:0]] <= wdisk;
		end
		rdata_q <= mem[idx_q];
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q      <= in_data;
			sum_q     <= '0;
			idx_q     <= '0;
			dropped_q <= (stdp_pkg::kind_t'(in_data.kind) == stdp_pkg::KIND_LOAD)
				&& (count_q >= SLOTS_C);
		end
		if (out_load) begin
			out_q.penalty      <= sum_q;
			out_q.load_dropped <= dropped_q;
			out_q.threat_count <= stdp_pkg::CNT_OUT_W'(count_q);
		end
		case (state_q)
			stdp_pkg::ST_LOAD_X, stdp_pkg::ST_LEN_X, stdp_pkg::ST_DA_X,
			stdp_pkg::ST_DB_X, stdp_pkg::ST_T_X, stdp_pkg::ST_P_X,
			stdp_pkg::ST_P_Y, stdp_pkg::ST_D_X, stdp_pkg::ST_W,
			stdp_pkg::ST_L: begin
				acc_q <= prod;
			end
			stdp_pkg::ST_LOAD_Y, stdp_pkg::ST_DA_Y: da_q <= sq_sum;
			stdp_pkg::ST_LEN_Y: len2_q <= sq_sum;
			stdp_pkg::ST_FETCH: begin
				lenf_q <= stdp_pkg::LENF_ONE + ((len2_q >= stdp_pkg::LEN2_CAP)
					? stdp_pkg::LENF_W'(stdp_pkg::LEN2_CAP)
					: {1'b0, len2_q[27:0]});
			end
			stdp_pkg::ST_RR: rr_q <= prod[stdp_pkg::RR_W-1:0];
			stdp_pkg::ST_T_Y: t_q <= t_sum;
			stdp_pkg::ST_T_CHK: begin
				if (t_q <= 52'sd0) begin
					u_q <= '0;
				end else begin
					u_q <= stdp_pkg::FRAC_ONE;
				end
			end
			stdp_pkg::ST_UDIV: begin
				if (div_rsp.done) begin
					u_q <= {1'b0, div_rsp.quo};
				end
			end
			stdp_pkg::ST_P_X2: begin
				epx_q <= 27'($signed({4'b0, in_q.seg_ax}) + px_off
					- $signed({4'b0, rdata_q.x}));
			end
			stdp_pkg::ST_P_Y2: begin
				epy_q <= 27'($signed({4'b0, in_q.seg_ay}) + px_off
					- $signed({4'b0, rdata_q.y}));
			end
			stdp_pkg::ST_D_Y: d_q <= sq_sum;
			stdp_pkg::ST_D_CHK: f_q <= stdp_pkg::FRAC_ONE;
			stdp_pkg::ST_FDIV: begin
				if (div_rsp.done) begin
					f_q <= {1'b0, div_rsp.quo};
				end
			end
			stdp_pkg::ST_ACC: begin
				sum_q <= sum_ext[stdp_pkg::PEN_W] ? stdp_pkg::PEN_MAX
					: sum_ext[stdp_pkg::PEN_W-1:0];
			end
			stdp_pkg::ST_NEXT: begin
				if (!last_disk) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOTS_C)
		else $error("disk count beyond table size");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && dropped_q |-> count_q == SLOTS_C)
		else $error("load dropped with room in the table");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stdp_pkg::ST_DONE && out_valid_q && out_stall) |=> $stable(out_q))
		else $error("pending result overwritten");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == stdp_pkg::ST_UDIV || state_q == stdp_pkg::ST_FDIV))
		else $error("divider result arrived outside a wait state");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	stdp_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	stdp_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [stdp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [stdp_pkg::COORD_W-1:0] cfg_wdata = '0;

	segment_threat_disk_penalty_top #(.THREAT_SLOTS(SLOTS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mirror of the disk table and start registers
	bit [stdp_pkg::COORD_W-1:0]  tbl_x [SLOTS];
	bit [stdp_pkg::COORD_W-1:0]  tbl_y [SLOTS];
	bit [stdp_pkg::RADIUS_W-1:0] tbl_r [SLOTS];
	bit [stdp_pkg::WEIGHT_W-1:0] tbl_w [SLOTS];
	bit                          tbl_in [SLOTS];
	int unsigned n_disks = 0;
	bit [stdp_pkg::COORD_W-1:0] route_x = '0, route_y = '0;

	stdp_pkg::in_t  items_pending [$];
	stdp_pkg::out_t results_due [$];
	int fails = 0, n_accepted = 0, n_checked = 0, n_queries = 0, n_hits = 0, n_drops = 0;
	int gap_left = 0, stall_left = 0;
	bit calm = 1'b0;	// no idling on either side
	bit in_fire = 1'b0;

	function automatic longint sqd(longint x, longint y, longint cx, longint cy);
		return (x - cx) * (x - cx) + (y - cy) * (y - cy);
	endfunction

	function automatic longint frac16(longint num, longint den);
		longint q, rem;
		q = 0;
		rem = num;
		for (int k = 0; k < 16; k++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic logic [stdp_pkg::PEN_W-1:0] segment_penalty(longint ax, longint ay,
			longint bx, longint by);
		longint dx, dy, len2, cx, cy, rr, t, px, py, d, u, f;
		longint unsigned lenf, sum, term;
		dx = bx - ax;
		dy = by - ay;
		len2 = dx * dx + dy * dy;
		if (len2 == 0)
			return '0;
		lenf = (64'd1 << 20) + ((len2 < (64'sd1 << 28)) ? len2 : (64'sd1 << 28));
		sum = 0;
		for (int i = 0; i < n_disks; i++) begin
			cx = tbl_x[i];
			cy = tbl_y[i];
			rr = longint'(tbl_r[i]) * longint'(tbl_r[i]);
			// a disk holding the start is ignored unless the segment heads inwards
			if (tbl_in[i] && sqd(bx, by, cx, cy) >= sqd(ax, ay, cx, cy))
				continue;
			t = (cx - ax) * dx + (cy - ay) * dy;
			if (t <= 0)
				u = 0;
			else if (t >= len2)
				u = 65536;
			else
				u = frac16(t, len2);
			px = ax + ((u * dx + 32768) >>> 16);
			py = ay + ((u * dy + 32768) >>> 16);
			d = sqd(px, py, cx, cy);
			if (d >= rr)
				continue;
			f = (d == 0) ? 65536 : frac16(rr - d, rr);
			term = (longint'(tbl_w[i]) * f * lenf) >> 36;
			sum += term;
			if (sum > 64'hFFFF_FFFF)
				sum = 64'hFFFF_FFFF;
		end
		return sum[stdp_pkg::PEN_W-1:0];
	endfunction

	function automatic stdp_pkg::out_t score_item(stdp_pkg::in_t it);
		stdp_pkg::out_t r;
		r = '0;
		case (stdp_pkg::kind_t'(it.kind))
			stdp_pkg::KIND_CLEAR: n_disks = 0;
			stdp_pkg::KIND_LOAD: begin
				if (n_disks >= SLOTS) begin
					r.load_dropped = 1'b1;
				end else begin
					tbl_x[n_disks] = it.threat_x;
					tbl_y[n_disks] = it.threat_y;
					tbl_r[n_disks] = it.threat_radius;
					tbl_w[n_disks] = it.threat_weight;
					tbl_in[n_disks] = sqd(route_x, route_y, it.threat_x, it.threat_y)
						< longint'(it.threat_radius) * longint'(it.threat_radius);
					n_disks++;
				end
			end
			stdp_pkg::KIND_QUERY: r.penalty = segment_penalty(it.seg_ax, it.seg_ay,
				it.seg_bx, it.seg_by);
			default: ;
		endcase
		r.threat_count = n_disks[stdp_pkg::CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver: new transaction at the falling edge once the last one was taken, after any random gap
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (items_pending.size() > 0) begin
				in_data <= items_pending.pop_front();
				in_valid <= 1'b1;
				gap_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			out_stall <= (stall_left > 0);
		end
	end

	// acceptance, prediction and result checking at the rising edge
	always @(posedge clk) begin
		stdp_pkg::out_t want;
		in_fire = in_valid && !in_stall;
		if (in_fire) begin
			if (stdp_pkg::kind_t'(in_data.kind) == stdp_pkg::KIND_QUERY)
				n_queries++;
			results_due.push_back(score_item(in_data));
			n_accepted++;
		end
		if (out_valid && !out_stall) begin
			n_checked++;
			if (results_due.size() == 0) begin
				$error("result with nothing outstanding");
				fails++;
			end else begin
				want = results_due.pop_front();
				if (out_data.penalty != 0)
					n_hits++;
				if (out_data.load_dropped)
					n_drops++;
				if (out_data.penalty !== want.penalty) begin
					$error("penalty: expected %0h actual %0h", want.penalty, out_data.penalty);
					fails++;
				end
				if (out_data.load_dropped !== want.load_dropped) begin
					$error("load_dropped: expected %0b actual %0b",
						want.load_dropped, out_data.load_dropped);
					fails++;
				end
				if (out_data.threat_count !== want.threat_count) begin
					$error("threat_count: expected %0d actual %0d",
						want.threat_count, out_data.threat_count);
					fails++;
				end
			end
		end
	end

	function automatic stdp_pkg::in_t noise_item();
		stdp_pkg::in_t it;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(stdp_pkg::in_t)-1:0];
		return it;
	endfunction

	function automatic stdp_pkg::in_t disk_item(int x, int y, int r, int w);
		stdp_pkg::in_t it;
		it = noise_item();
		it.kind = stdp_pkg::KIND_LOAD;
		it.threat_x = stdp_pkg::COORD_W'(x);
		it.threat_y = stdp_pkg::COORD_W'(y);
		it.threat_radius = stdp_pkg::RADIUS_W'(r);
		it.threat_weight = stdp_pkg::WEIGHT_W'(w);
		return it;
	endfunction

	function automatic stdp_pkg::in_t seg_item(int ax, int ay, int bx, int by);
		stdp_pkg::in_t it;
		it = noise_item();
		it.kind = stdp_pkg::KIND_QUERY;
		it.seg_ax = stdp_pkg::COORD_W'(ax);
		it.seg_ay = stdp_pkg::COORD_W'(ay);
		it.seg_bx = stdp_pkg::COORD_W'(bx);
		it.seg_by = stdp_pkg::COORD_W'(by);
		return it;
	endfunction

	function automatic stdp_pkg::in_t plain_item(stdp_pkg::kind_t k);
		stdp_pkg::in_t it;
		it = noise_item();
		it.kind = k;
		return it;
	endfunction

	// wait until nothing is queued, driven or outstanding, sampled after the edge settles
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (items_pending.size() != 0 || in_valid || results_due.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_reg(stdp_pkg::cfg_reg_t idx, logic [stdp_pkg::COORD_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == stdp_pkg::REG_START_X) route_x = val;
		else route_y = val;
	endtask

	initial begin
		int sent, base_x, base_y, span, n, q;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: start at (0x100, 0x100), a huge disk around it
		set_reg(stdp_pkg::REG_START_X, 24'h000100);
		set_reg(stdp_pkg::REG_START_Y, 24'h000100);
		items_pending.push_back(plain_item(stdp_pkg::KIND_CLEAR));
		items_pending.push_back(seg_item(0, 0, 24'hFFFFFF, 24'hFFFFFF));
		items_pending.push_back(plain_item(stdp_pkg::KIND_NONE));
		items_pending.push_back(disk_item(24'h004000, 24'h004000, 132608, 24576));
		items_pending.push_back(disk_item(24'h008000, 24'h004000, 0, 24576));
		items_pending.push_back(disk_item(24'h00A000, 24'h00A000, 20000, 0));
		items_pending.push_back(disk_item(24'hFFFFFF, 24'hFFFFFF, 132608, 6144));
		items_pending.push_back(seg_item(24'h5000, 24'h5000, 24'h5000, 24'h5000));
		items_pending.push_back(seg_item(24'h0100, 24'h0100, 24'h0000, 24'h0000));
		items_pending.push_back(seg_item(24'h0100, 24'h0100, 24'h8000, 24'h4000));
		items_pending.push_back(seg_item(24'h6000, 24'h0000, 24'h2000, 24'h8000));
		items_pending.push_back(seg_item(24'h4000, 24'h4000, 24'h4080, 24'h4000));
		items_pending.push_back(seg_item(24'hFFFFFF, 24'hFFFFFF, 24'hFF0000, 24'hFFFF00));
		items_pending.push_back(seg_item(24'hFFFFFF, 0, 0, 24'hFFFFFF));
		for (int i = 0; i < SLOTS; i++)
			items_pending.push_back(disk_item(24'h3000 + 64 * i, 24'h3000, 4000, 24576));
		items_pending.push_back(seg_item(24'h2000, 24'h3000, 24'h5000, 24'h3000));
		items_pending.push_back(plain_item(stdp_pkg::KIND_CLEAR));
		sent = 16 + SLOTS;
		set_reg(stdp_pkg::REG_START_X, 24'hFFFFFF);
		set_reg(stdp_pkg::REG_START_Y, 24'hFFFFFF);
		set_reg(stdp_pkg::REG_START_X, 24'h000000);
		set_reg(stdp_pkg::REG_START_Y, 24'h000000);

		// random phases: maybe move the start, maybe clear, load 0 to 8 disks (now and then 60 to 70), query around them
		while (sent < 1150) begin
			span = 1 << $urandom_range(12, 18);
			base_x = $urandom_range(0, 24'hFFFFFF - span);
			base_y = $urandom_range(0, 24'hFFFFFF - span);
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0) begin
				set_reg(stdp_pkg::REG_START_X,
					stdp_pkg::COORD_W'(base_x + $urandom_range(0, span)));
				set_reg(stdp_pkg::REG_START_Y,
					stdp_pkg::COORD_W'(base_y + $urandom_range(0, span)));
			end
			if ($urandom_range(0, 1)) begin
				items_pending.push_back(plain_item(stdp_pkg::KIND_CLEAR));
				sent++;
			end
			n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
			for (int i = 0; i < n; i++)
				items_pending.push_back(disk_item(base_x + $urandom_range(0, span),
					base_y + $urandom_range(0, span),
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 132608)
						: $urandom_range(0, span),
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
						: $urandom_range(6144, 24576)));
			q = $urandom_range(2, 8);
			for (int i = 0; i < q; i++) begin
				if ($urandom_range(0, 9) == 0)
					items_pending.push_back(noise_item());
				else if ($urandom_range(0, 19) == 0)
					items_pending.push_back(seg_item(int'(route_x), int'(route_y),
						base_x + $urandom_range(0, span), base_y + $urandom_range(0, span)));
				else
					items_pending.push_back(seg_item(base_x + $urandom_range(0, span),
						base_y + $urandom_range(0, span),
						base_x + $urandom_range(0, span), base_y + $urandom_range(0, span)));
			end
			sent += n + q;
			drain();
		end

		calm = 1'b0;
		drain();
		repeat (200) @(negedge clk);
		$display("Ran %0d transactions (%0d queries, %0d non-zero penalties, %0d drops),",
			n_accepted, n_queries, n_hits, n_drops);
		$display("checked %0d results across random start settings and table fills.", n_checked);
		if (fails == 0 && results_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ segment_threat_disk_penalty_top.f @@
src/stdp_pkg.sv
src/stdp_frac16.sv
src/segment_threat_disk_penalty_top.sv
bench/testbench.sv
